/* hdl/bed_pkg.sv */
// Shared types and character constants for the backslash escape decoder.
package bed_pkg;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_SEVEN  = 8'h37;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX = 8'h66;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UF     = 8'h46;
    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_E      = 8'h65;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_V      = 8'h76;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_ESC = 8'h1B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_HT  = 8'h09;
    localparam logic [7:0] CODE_VT  = 8'h0B;

    localparam int RUN_MAX = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_final;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_run_end;
        logic       out_text_end;
    } out_item_t;

    typedef struct packed {
        logic [1:0]                  count;
        out_item_t [RUN_MAX-1:0]     items;
    } run_t;

endpackage

/* hdl/bed_decode.sv */
// Escape parser: parse state registers and the per-transaction decode into a result run.
module bed_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  bed_pkg::in_item_t item,
    output bed_pkg::run_t     run
);

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX   = 2'd2,
        MODE_OCT   = 2'd3
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [8:0] value_reg, value_next;
    logic [1:0] count_reg, count_next;

    logic [7:0] c;
    logic       fin;
    logic       is_bslash;
    logic [3:0] hex_digit;
    logic       hex_ok;
    logic       oct_ok;
    logic [8:0] hex_acc;
    logic [8:0] oct_acc;
    logic [1:0] count_inc;
    logic [7:0] b0, b1, b2;
    logic [1:0] n;
    logic [1:0] last;

    assign c         = item.in_byte;
    assign fin       = item.in_final;
    assign is_bslash = (c == bed_pkg::CHAR_BSLASH);
    assign oct_ok    = (c >= bed_pkg::CHAR_ZERO) && (c <= bed_pkg::CHAR_SEVEN);
    assign hex_acc   = {value_reg[4:0], hex_digit};
    assign oct_acc   = {value_reg[5:0], c[2:0]};
    assign count_inc = count_reg + 2'd1;

    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if ((c >= bed_pkg::CHAR_ZERO) && (c <= bed_pkg::CHAR_NINE))
        begin
            hex_digit = c[3:0];
        end
        else if (((c >= bed_pkg::CHAR_LA) && (c <= bed_pkg::CHAR_LF_HEX)) ||
                 ((c >= bed_pkg::CHAR_UA) && (c <= bed_pkg::CHAR_UF)))
        begin
            hex_digit = c[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        value_next = value_reg;
        count_next = count_reg;
        b0 = 8'd0;
        b1 = 8'd0;
        b2 = 8'd0;
        n  = 2'd0;
        unique case (mode_reg)
            MODE_PLAIN:
            begin
                if (is_bslash && !fin)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    b0 = c;
                    n  = 2'd1;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_PLAIN;
                n = 2'd1;
                unique case (c)
                    bed_pkg::CHAR_LA:     b0 = bed_pkg::CODE_BEL;
                    bed_pkg::CHAR_B:      b0 = bed_pkg::CODE_BS;
                    bed_pkg::CHAR_E:      b0 = bed_pkg::CODE_ESC;
                    bed_pkg::CHAR_LF_HEX: b0 = bed_pkg::CODE_FF;
                    bed_pkg::CHAR_N:      b0 = bed_pkg::CODE_LF;
                    bed_pkg::CHAR_R:      b0 = bed_pkg::CODE_CR;
                    bed_pkg::CHAR_T:      b0 = bed_pkg::CODE_HT;
                    bed_pkg::CHAR_V:      b0 = bed_pkg::CODE_VT;
                    bed_pkg::CHAR_BSLASH: b0 = bed_pkg::CHAR_BSLASH;
                    bed_pkg::CHAR_X:
                    begin
                        value_next = 9'd0;
                        count_next = 2'd0;
                        if (fin)
                        begin
                            b0 = bed_pkg::CHAR_BSLASH;
                            b1 = bed_pkg::CHAR_X;
                            n  = 2'd2;
                        end
                        else
                        begin
                            mode_next = MODE_HEX;
                            n = 2'd0;
                        end
                    end
                    bed_pkg::CHAR_ZERO:
                    begin
                        value_next = 9'd0;
                        count_next = 2'd0;
                        n = 2'd0;
                        if (!fin)
                        begin
                            mode_next = MODE_OCT;
                        end
                    end
                    default:
                    begin
                        b0 = bed_pkg::CHAR_BSLASH;
                        b1 = c;
                        n  = 2'd2;
                    end
                endcase
            end
            MODE_HEX:
            begin
                if (hex_ok)
                begin
                    if ((count_inc >= 2'd2) || fin)
                    begin
                        b0 = hex_acc[7:0];
                        n  = 2'd1;
                        mode_next  = MODE_PLAIN;
                        value_next = 9'd0;
                        count_next = 2'd0;
                    end
                    else
                    begin
                        value_next = hex_acc;
                        count_next = count_inc;
                    end
                end
                else
                begin
                    mode_next  = MODE_PLAIN;
                    value_next = 9'd0;
                    count_next = 2'd0;
                    if (count_reg != 2'd0)
                    begin
                        b0 = value_reg[7:0];
                        if (is_bslash && !fin)
                        begin
                            mode_next = MODE_ESC;
                            n = 2'd1;
                        end
                        else
                        begin
                            b1 = c;
                            n  = 2'd2;
                        end
                    end
                    else
                    begin
                        b0 = bed_pkg::CHAR_BSLASH;
                        b1 = bed_pkg::CHAR_X;
                        if (is_bslash && !fin)
                        begin
                            mode_next = MODE_ESC;
                            n = 2'd2;
                        end
                        else
                        begin
                            b2 = c;
                            n  = 2'd3;
                        end
                    end
                end
            end
            MODE_OCT:
            begin
                if (oct_ok)
                begin
                    if ((count_inc >= 2'd3) || fin)
                    begin
                        b0 = oct_acc[7:0];
                        n  = 2'd1;
                        mode_next  = MODE_PLAIN;
                        value_next = 9'd0;
                        count_next = 2'd0;
                    end
                    else
                    begin
                        value_next = oct_acc;
                        count_next = count_inc;
                    end
                end
                else
                begin
                    mode_next  = MODE_PLAIN;
                    value_next = 9'd0;
                    count_next = 2'd0;
                    if (count_reg != 2'd0)
                    begin
                        b0 = value_reg[7:0];
                        if (is_bslash && !fin)
                        begin
                            mode_next = MODE_ESC;
                            n = 2'd1;
                        end
                        else
                        begin
                            b1 = c;
                            n  = 2'd2;
                        end
                    end
                    else
                    begin
                        if (is_bslash && !fin)
                        begin
                            mode_next = MODE_ESC;
                            n = 2'd0;
                        end
                        else
                        begin
                            b0 = c;
                            n  = 2'd1;
                        end
                    end
                end
            end
            default:
            begin
                mode_next = MODE_PLAIN;
            end
        endcase
    end

    assign last = (n == 2'd0) ? 2'd0 : n - 2'd1;

    always_comb
    begin
        run.count = (n == 2'd0) ? 2'd1 : n;
        run.items[0].out_byte = b0;
        run.items[1].out_byte = b1;
        run.items[2].out_byte = b2;
        run.items[0].out_valid = (n != 2'd0);
        run.items[1].out_valid = (n >= 2'd2);
        run.items[2].out_valid = (n == 2'd3);
        run.items[0].out_run_end = (last == 2'd0);
        run.items[1].out_run_end = (last == 2'd1);
        run.items[2].out_run_end = (last == 2'd2);
        run.items[0].out_text_end = (last == 2'd0) && fin;
        run.items[1].out_text_end = (last == 2'd1) && fin;
        run.items[2].out_text_end = (last == 2'd2) && fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            value_reg <= 9'd0;
            count_reg <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            value_reg <= value_next;
            count_reg <= count_next;
        end
    end

endmodule

/* hdl/bed_run_buf.sv */
// Result register that holds one decoded run and hands it out one transaction per cycle while out_ready is high.
module bed_run_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  bed_pkg::run_t      run,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output bed_pkg::out_item_t out_data
);

    bed_pkg::out_item_t [bed_pkg::RUN_MAX-1:0] items_reg;
    logic [1:0] rem_reg;
    logic       pop;

    assign out_valid = (rem_reg != 2'd0);
    assign out_data  = items_reg[0];
    assign pop       = out_valid && out_ready;
    assign can_load  = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
        end
        else if (load)
        begin
            rem_reg <= run.count;
        end
        else if (pop)
        begin
            rem_reg <= rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            items_reg <= run.items;
        end
        else if (pop)
        begin
            items_reg[0] <= items_reg[1];
            items_reg[1] <= items_reg[2];
        end
    end

endmodule

/* hdl/backslash_escape_decoder_top.sv */
// The first result of a transaction is offered in the cycle after it is accepted.
// One input transaction per cycle while each yields a single result and out_ready is
// high; an input with k results (k up to 3) keeps new input out until its last is taken.
// Reset: rst_n clears the parse state to plain text and empties the result register.
module backslash_escape_decoder_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bed_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bed_pkg::out_item_t out_data
);

    bed_pkg::run_t run;
    logic          accept;

    assign accept = in_valid && in_ready;

    bed_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .run    (run)
    );

    bed_run_buf u_run_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .run       (run),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the backslash escape decoder: a directed table, then random strings.
module testbench;

    typedef enum logic [1:0] {PM_TEXT, PM_ESCAPE, PM_HEX, PM_OCTAL} parse_mode_e;

    typedef struct packed {
        bed_pkg::in_item_t  item;
        logic               typed;
        bed_pkg::out_item_t want;
    } text_row_t;

    localparam int RANDOM_ITEMS = 432;
    localparam int QUIET_TAIL   = 80;
    localparam int HOLD_CYCLES  = 60;
    localparam int HOLD_AT_ITEM = 120;
    localparam int MAX_REPORTS  = 10;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_G       = 8'h67;
    localparam logic [7:0] CHAR_Q       = 8'h71;
    localparam logic [8:0][7:0] NAMED_ESC = {bed_pkg::CHAR_LA, bed_pkg::CHAR_B, bed_pkg::CHAR_E,
                                             bed_pkg::CHAR_LF_HEX, bed_pkg::CHAR_N,
                                             bed_pkg::CHAR_R, bed_pkg::CHAR_T, bed_pkg::CHAR_V,
                                             bed_pkg::CHAR_BSLASH};

    localparam text_row_t DIRECTED [0:27] = '{
        '{'{CHAR_UPPER_A, 1'b0}, 1'b1, '{CHAR_UPPER_A, 1'b1, 1'b1, 1'b0}},
        '{'{8'hFF, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
        '{'{8'h01, 1'b1}, 1'b1, '{8'h01, 1'b1, 1'b1, 1'b1}},
        '{'{bed_pkg::CHAR_BSLASH, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
        '{'{bed_pkg::CHAR_LA, 1'b0}, 1'b1, '{bed_pkg::CODE_BEL, 1'b1, 1'b1, 1'b0}},
        '{'{bed_pkg::CHAR_BSLASH, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
        '{'{bed_pkg::CHAR_E, 1'b0}, 1'b1, '{bed_pkg::CODE_ESC, 1'b1, 1'b1, 1'b0}},
        '{'{bed_pkg::CHAR_BSLASH, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_BSLASH, 1'b0}, 1'b1, '{bed_pkg::CHAR_BSLASH, 1'b1, 1'b1, 1'b0}},
        '{'{bed_pkg::CHAR_BSLASH, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_X, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_UF, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_LF_HEX, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_BSLASH, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_ZERO, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_SEVEN, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_SEVEN, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_SEVEN, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_BSLASH, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_X, 1'b0}, 1'b0, '0},
        '{'{CHAR_G, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_BSLASH, 1'b0}, 1'b0, '0},
        '{'{CHAR_Q, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_BSLASH, 1'b1}, 1'b1, '{bed_pkg::CHAR_BSLASH, 1'b1, 1'b1, 1'b1}},
        '{'{bed_pkg::CHAR_BSLASH, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_ZERO, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{'{bed_pkg::CHAR_BSLASH, 1'b0}, 1'b0, '0},
        '{'{bed_pkg::CHAR_X, 1'b1}, 1'b0, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    bed_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    bed_pkg::out_item_t out_data;

    text_row_t          text_stream [$];
    text_row_t          offered_row;
    bed_pkg::out_item_t decoded_due [$];
    bed_pkg::out_item_t step_out [$];
    parse_mode_e        mode_now;
    logic [8:0]         digit_acc;
    logic [1:0]         digit_cnt;
    int                 mismatch_count;
    int                 sent_index;
    bit                 quiet;

    backslash_escape_decoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int hex_digit(logic [7:0] c);
        if (c >= bed_pkg::CHAR_ZERO && c <= bed_pkg::CHAR_NINE)
            return int'(c - bed_pkg::CHAR_ZERO);
        if (c >= bed_pkg::CHAR_LA && c <= bed_pkg::CHAR_LF_HEX)
            return int'(c - bed_pkg::CHAR_LA) + 10;
        if (c >= bed_pkg::CHAR_UA && c <= bed_pkg::CHAR_UF)
            return int'(c - bed_pkg::CHAR_UA) + 10;
        return -1;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        if (step_out.size() < bed_pkg::RUN_MAX)
            step_out.push_back(bed_pkg::out_item_t'{b, 1'b1, 1'b0, 1'b0});
    endfunction

    function automatic void take_text(logic [7:0] c, logic fin);
        if (c == bed_pkg::CHAR_BSLASH && !fin)
            mode_now = PM_ESCAPE;
        else
            put_byte(c);
    endfunction

    function automatic void clear_digits();
        mode_now  = PM_TEXT;
        digit_acc = '0;
        digit_cnt = '0;
    endfunction

    // Advances the decoder state by one input byte and leaves its results in step_out.
    function automatic void decode_byte(bed_pkg::in_item_t it);
        logic [7:0]         c;
        logic               fin;
        int                 d;
        bed_pkg::out_item_t last;
        c = it.in_byte;
        fin = it.in_final;
        step_out.delete();
        case (mode_now)
            PM_TEXT:
                take_text(c, fin);
            PM_ESCAPE:
            begin
                mode_now = PM_TEXT;
                case (c)
                    bed_pkg::CHAR_LA:     put_byte(bed_pkg::CODE_BEL);
                    bed_pkg::CHAR_B:      put_byte(bed_pkg::CODE_BS);
                    bed_pkg::CHAR_E:      put_byte(bed_pkg::CODE_ESC);
                    bed_pkg::CHAR_LF_HEX: put_byte(bed_pkg::CODE_FF);
                    bed_pkg::CHAR_N:      put_byte(bed_pkg::CODE_LF);
                    bed_pkg::CHAR_R:      put_byte(bed_pkg::CODE_CR);
                    bed_pkg::CHAR_T:      put_byte(bed_pkg::CODE_HT);
                    bed_pkg::CHAR_V:      put_byte(bed_pkg::CODE_VT);
                    bed_pkg::CHAR_BSLASH: put_byte(bed_pkg::CHAR_BSLASH);
                    bed_pkg::CHAR_X:
                    begin
                        clear_digits();
                        if (fin)
                        begin
                            put_byte(bed_pkg::CHAR_BSLASH);
                            put_byte(bed_pkg::CHAR_X);
                        end
                        else
                            mode_now = PM_HEX;
                    end
                    bed_pkg::CHAR_ZERO:
                    begin
                        clear_digits();
                        if (!fin)
                            mode_now = PM_OCTAL;
                    end
                    default:
                    begin
                        put_byte(bed_pkg::CHAR_BSLASH);
                        put_byte(c);
                    end
                endcase
            end
            PM_HEX:
            begin
                d = hex_digit(c);
                if (d >= 0)
                begin
                    digit_acc = {digit_acc[4:0], 4'(d)};
                    digit_cnt = digit_cnt + 2'd1;
                    if (digit_cnt >= 2'd2 || fin)
                    begin
                        put_byte(digit_acc[7:0]);
                        clear_digits();
                    end
                end
                else
                begin
                    if (digit_cnt > 0)
                        put_byte(digit_acc[7:0]);
                    else
                    begin
                        put_byte(bed_pkg::CHAR_BSLASH);
                        put_byte(bed_pkg::CHAR_X);
                    end
                    clear_digits();
                    take_text(c, fin);
                end
            end
            default:
            begin
                if (c >= bed_pkg::CHAR_ZERO && c <= bed_pkg::CHAR_SEVEN)
                begin
                    digit_acc = {digit_acc[5:0], c[2:0]};
                    digit_cnt = digit_cnt + 2'd1;
                    if (digit_cnt >= 2'd3 || fin)
                    begin
                        put_byte(digit_acc[7:0]);
                        clear_digits();
                    end
                end
                else
                begin
                    if (digit_cnt > 0)
                        put_byte(digit_acc[7:0]);
                    clear_digits();
                    take_text(c, fin);
                end
            end
        endcase
        if (step_out.size() == 0)
            step_out.push_back('0);
        last = step_out.pop_back();
        last.out_run_end = 1'b1;
        last.out_text_end = fin;
        step_out.push_back(last);
    endfunction

    function automatic logic [7:0] random_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return bed_pkg::CHAR_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? bed_pkg::CHAR_LA : bed_pkg::CHAR_UA) + 8'(v - 10);
    endfunction

    // Directed rows, then random strings mostly of escape sequences, with plain bytes mixed in as noise.
    function automatic void build_text_stream();
        logic [7:0] text [$];
        text_row_t  row;
        int         tokens;
        int         n;
        for (int i = 0; i < $size(DIRECTED); i++)
            text_stream.push_back(DIRECTED[i]);
        while (text_stream.size() < $size(DIRECTED) + RANDOM_ITEMS)
        begin
            text.delete();
            tokens = $urandom_range(1, 6);
            for (int t = 0; t < tokens; t++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                        text.push_back(8'($urandom_range(1, 255)));
                    3, 4:
                    begin
                        text.push_back(bed_pkg::CHAR_BSLASH);
                        text.push_back(NAMED_ESC[$urandom_range(0, 8)]);
                    end
                    5, 6:
                    begin
                        text.push_back(bed_pkg::CHAR_BSLASH);
                        text.push_back(bed_pkg::CHAR_X);
                        n = $urandom_range(0, 3);
                        for (int k = 0; k < n; k++)
                            text.push_back(random_hex_char());
                    end
                    7:
                    begin
                        text.push_back(bed_pkg::CHAR_BSLASH);
                        text.push_back(bed_pkg::CHAR_ZERO);
                        n = $urandom_range(0, 4);
                        for (int k = 0; k < n; k++)
                            text.push_back(bed_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)));
                    end
                    8:
                    begin
                        text.push_back(bed_pkg::CHAR_BSLASH);
                        text.push_back(8'($urandom_range(1, 255)));
                    end
                    default:
                        text.push_back(random_hex_char());
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                text.push_back(bed_pkg::CHAR_BSLASH);
            foreach (text[k])
            begin
                row = '0;
                row.item.in_byte = text[k];
                row.item.in_final = (k == text.size() - 1);
                text_stream.push_back(row);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        bed_pkg::out_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(in_data);
                if (offered_row.typed)
                    decoded_due.push_back(offered_row.want);
                else
                    foreach (step_out[k])
                        decoded_due.push_back(step_out[k]);
            end
            if (out_valid && out_ready)
            begin
                if (decoded_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected transaction: byte %h valid %b run_end %b text_end %b",
                                 out_data.out_byte, out_data.out_valid, out_data.out_run_end,
                                 out_data.out_text_end);
                end
                else
                begin
                    want = decoded_due.pop_front();
                    if (out_data !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: expected byte %h valid %b run_end %b text_end %b, %s",
                                     want.out_byte, want.out_valid, want.out_run_end,
                                     want.out_text_end,
                                     $sformatf("got byte %h valid %b run_end %b text_end %b",
                                               out_data.out_byte, out_data.out_valid,
                                               out_data.out_run_end, out_data.out_text_end));
                    end
                end
            end
        end
    end

    initial
    begin
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sent_index >= HOLD_AT_ITEM && !held && !quiet)
            begin
                held = 1'b1;
                out_ready = 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        offered_row = '0;
        mismatch_count = 0;
        sent_index = 0;
        quiet = 1'b0;
        clear_digits();
        build_text_stream();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < text_stream.size(); i++)
        begin
            quiet = (i >= text_stream.size() - QUIET_TAIL);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            offered_row = text_stream[i];
            in_data = offered_row.item;
            in_valid = 1'b1;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            sent_index = i + 1;
            @(negedge clk);
        end
        in_valid = 1'b0;
        wait_cycles = 0;
        while (decoded_due.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (decoded_due.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected transactions never arrived", decoded_due.size());
        end
        if (mismatch_count == 0)
            $display("backslash_escape_decoder_top regression: pass");
        else
            $display("backslash_escape_decoder_top regression: fail");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("backslash_escape_decoder_top regression: fail");
        $finish;
    end

endmodule
